[rtl/gpio_edge_pulse_capture_defines.svh]
// ----------------------------------------------------------------------------
// gpio_edge_pulse_capture_defines
// Assertion macros shared by the edge and pulse capture RTL.
// ----------------------------------------------------------------------------
`ifndef GPIO_EDGE_PULSE_CAPTURE_DEFINES_SVH
`define GPIO_EDGE_PULSE_CAPTURE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define GEP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define GEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/gep_pkg.sv]
// ----------------------------------------------------------------------------
// gep_pkg
// Shared widths, register codes, types and helpers of the edge/pulse capture.
// ----------------------------------------------------------------------------
package gep_pkg;

   localparam int PIN_W         = 31;
   localparam int TIME_W        = 64;
   localparam int PIN_INDEX_W   = 5;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 31;
   localparam int PIN_COUNT_DEF = 31;
   localparam int QUE_DEPTH     = 2;
   localparam int QUE_PTR_W     = $clog2(QUE_DEPTH);
   localparam int QUE_CNT_W     = $clog2(QUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IRQ_ENABLE   = 2'd0,
      CSR_ENABLED_PINS = 2'd1,
      CSR_PULSE_PINS   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              irq_enable;
      logic [PIN_W-1:0]  enabled_pins;
      logic [PIN_W-1:0]  pulse_pins;
   } cfg_type;

   // One classified port event waiting for the back end
   typedef struct packed {
      logic [PIN_W-1:0]  fire;
      logic [PIN_W-1:0]  levels;
      logic [TIME_W-1:0] event_time;
   } entry_type;

   // Number of pins that really exist
   function automatic int active_pins(input int pin_count);
      return (pin_count < PIN_W) ? pin_count : PIN_W;
   endfunction

   // Mask with the low 'active' pins set
   function automatic logic [PIN_W-1:0] pin_mask(input int active);
      logic [PIN_W-1:0] m;
      for (int i = 0; i < PIN_W; i++) begin
         m[i] = (i < active);
      end
      return m;
   endfunction

   // Index of the lowest set bit, zero when none is set
   function automatic logic [PIN_INDEX_W-1:0] lowest_set(input logic [PIN_W-1:0] vec);
      logic [PIN_INDEX_W-1:0] idx;
      idx = '0;
      for (int i = PIN_W - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = PIN_INDEX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[rtl/gep_front.sv]
// ----------------------------------------------------------------------------
// gep_front
// Accepts port events, compares levels with the awaited levels and queues
// the set of firing pins.
// ----------------------------------------------------------------------------
module gep_front import gep_pkg::*; #(
   parameter int PIN_COUNT = PIN_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [PIN_W-1:0]  req_pin_levels,
   input  logic [TIME_W-1:0] req_event_time,
   input  logic              que_full,
   output logic              push,
   output entry_type         push_entry
);

   localparam int ACTIVE = active_pins(PIN_COUNT);
   localparam logic [PIN_W-1:0] ACT_MASK = pin_mask(ACTIVE);

   logic [PIN_W-1:0] await_low_ff;
   logic [PIN_W-1:0] await_low_in;
   logic [PIN_W-1:0] en_mask;
   logic [PIN_W-1:0] fire;
   logic             accept;
   logic             live;

   assign req_stall = que_full;
   assign accept    = req_valid && !que_full;
   assign live      = accept && cfg.irq_enable;

   // Classify: a pin fires when its level equals the awaited level
   assign en_mask = cfg.enabled_pins & ACT_MASK;
   assign fire    = (req_pin_levels ^ await_low_ff) & en_mask;

   // Drop events without firing pins
   assign push                  = live && (fire != '0);
   assign push_entry.fire       = fire;
   assign push_entry.levels     = req_pin_levels;
   assign push_entry.event_time = req_event_time;

   // Await the opposite of the current level on every enabled pin
   always_comb begin
      await_low_in = await_low_ff;
      if (live) begin
         await_low_in = (await_low_ff & ~en_mask) | (req_pin_levels & en_mask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         await_low_ff <= ACT_MASK;
      end else begin
         await_low_ff <= await_low_in;
      end
   end

endmodule

[rtl/gep_queue.sv]
// ----------------------------------------------------------------------------
// gep_queue
// Short queue of classified port events between front and back end.
// ----------------------------------------------------------------------------
`include "gpio_edge_pulse_capture_defines.svh"

module gep_queue import gep_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   entry_type              mem_ff [QUE_DEPTH];
   logic [QUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUE_CNT_W-1:0]   count_ff;
   logic [QUE_CNT_W-1:0]   count_in;

   assign full  = (count_ff == QUE_CNT_W'(QUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `GEP_ASSERT_IMPL(a_que_no_overflow, clock, reset, push, !full, "queue push while full")
   `GEP_ASSERT_IMPL(a_que_no_underflow, clock, reset, pop, !empty, "queue pop while empty")
   `GEP_ASSERT_NEXT(a_que_count_up, clock, reset, push && !pop,
      count_ff == $past(count_ff) + 1'b1, "queue count did not rise")

endmodule

[rtl/gep_back.sv]
// ----------------------------------------------------------------------------
// gep_back
// Walks the firing pins of one port event, one pin per cycle while rsp is
// not stalled, keeps per-pin pulse start times and drives the result register.
// ----------------------------------------------------------------------------
`include "gpio_edge_pulse_capture_defines.svh"

module gep_back import gep_pkg::*; #(
   parameter int PIN_COUNT = PIN_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   que_empty,
   input  entry_type              head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIN_INDEX_W-1:0] rsp_pin_index,
   output logic                   rsp_rising,
   output logic                   rsp_is_pulse,
   output logic [TIME_W-1:0]      rsp_time_value,
   output logic                   rsp_last_of_run
);

   localparam int ACTIVE    = active_pins(PIN_COUNT);
   localparam int MEM_IDX_W = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

   // Scan state of the current transaction
   logic [PIN_W-1:0]       rem_ff;
   logic [PIN_W-1:0]       rem_in;
   logic [PIN_W-1:0]       levels_ff;
   logic [TIME_W-1:0]      time_ff;

   // Pulse start times; nz_ff marks a stored nonzero time
   logic [TIME_W-1:0]      prev_mem_ff [ACTIVE];
   logic [PIN_W-1:0]       nz_ff;
   logic [PIN_W-1:0]       nz_in;

   // Result register
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [PIN_INDEX_W-1:0] rsp_pin_index_ff;
   logic                   rsp_rising_ff;
   logic                   rsp_is_pulse_ff;
   logic [TIME_W-1:0]      rsp_time_value_ff;
   logic                   rsp_last_of_run_ff;

   logic [PIN_INDEX_W-1:0] sel_idx;
   logic [MEM_IDX_W-1:0]   mem_idx;
   logic [PIN_W-1:0]       sel_bit;
   logic [PIN_W-1:0]       emit_rem;
   logic [TIME_W-1:0]      prev_rd;
   logic [TIME_W-1:0]      duration;
   logic                   out_free;
   logic                   step;
   logic                   is_pulse;
   logic                   emit;
   logic                   last;

   // Pick the lowest remaining firing pin
   assign sel_idx = lowest_set(rem_ff);
   assign mem_idx = sel_idx[MEM_IDX_W-1:0];
   assign sel_bit = rem_ff & (~rem_ff + 1'b1);

   assign pop      = !que_empty && (rem_ff == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step     = (rem_ff != '0) && out_free;

   // Suppress a pulse pin without a stored start time
   assign is_pulse = (sel_bit & cfg.pulse_pins) != '0;
   assign emit     = !is_pulse || ((sel_bit & nz_ff) != '0);
   assign emit_rem = rem_ff & (~cfg.pulse_pins | nz_ff);
   assign last     = (emit_rem & ~sel_bit) == '0;

   assign prev_rd  = prev_mem_ff[mem_idx];
   assign duration = time_ff - prev_rd;

   // Load a new transaction or retire the selected pin
   always_comb begin
      rem_in = rem_ff;
      nz_in  = nz_ff;
      if (pop) begin
         rem_in = head.fire;
      end else if (step) begin
         rem_in = rem_ff & ~sel_bit;
         if (is_pulse) begin
            nz_in = (nz_ff & ~sel_bit) | (time_ff != '0 ? sel_bit : '0);
         end
      end
   end

   // Hold the result while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         nz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the popped transaction
   always_ff @(posedge clock) begin
      if (pop) begin
         levels_ff <= head.levels;
         time_ff   <= head.event_time;
      end
   end

   // Record the pulse start time
   always_ff @(posedge clock) begin
      if (step && is_pulse) begin
         prev_mem_ff[mem_idx] <= time_ff;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_pin_index_ff   <= sel_idx;
         rsp_rising_ff      <= (levels_ff & sel_bit) != '0;
         rsp_is_pulse_ff    <= is_pulse;
         rsp_time_value_ff  <= is_pulse ? duration : time_ff;
         rsp_last_of_run_ff <= last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pin_index   = rsp_pin_index_ff;
   assign rsp_rising      = rsp_rising_ff;
   assign rsp_is_pulse    = rsp_is_pulse_ff;
   assign rsp_time_value  = rsp_time_value_ff;
   assign rsp_last_of_run = rsp_last_of_run_ff;

   `GEP_ASSERT_IMPL(a_back_pop_idle, clock, reset, pop, rem_ff == '0, "pop during a scan")
   `GEP_ASSERT_NEXT(a_back_step_one, clock, reset, step,
      $countones(rem_ff) == $past($countones(rem_ff)) - 1,
      "scan did not retire exactly one pin")
   `GEP_ASSERT_NEXT(a_back_emit_shown, clock, reset, step && emit, rsp_valid_ff,
      "emitted pin not presented")

endmodule

[rtl/gpio_edge_pulse_capture.sv]
// ----------------------------------------------------------------------------
// gpio_edge_pulse_capture
// Per-pin edge and pulse-width capture for one GPIO port.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one port sense transaction (pin level snapshot and timestamp),
//            taken when req_valid is high and req_stall is low.
//   rsp_*  : one pin transaction per firing pin, ascending; none for a pulse
//            pin without start time; rsp_last_of_run ends a port transaction.
//   csr_*  : register write port (irq enable, enabled pins, pulse pins);
//            write only while the block is idle.
// Flow: a port transaction enters a two-entry queue the cycle it is taken;
//   the back end pops it once the previous pin walk is done, then walks one
//   firing pin per cycle (suppressed pulse pins included) while rsp is not
//   stalled. The first result passes the queue, the scan state and the
//   result register.
// The pin walk of the back end sets the rate; the front end keeps taking
//   transactions while the queue has room, so req_stall rises only when
//   the queue is full.
// A stalled rsp side holds the result register and freezes the pin walk.
// Reset: every active pin awaits low, pulse start times read as none, irq enabled,
//   no pins enabled, queue and result register empty.
// ----------------------------------------------------------------------------
module gpio_edge_pulse_capture import gep_pkg::*; #(
   parameter int PIN_COUNT = PIN_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIN_W-1:0]       req_pin_levels,
   input  logic [TIME_W-1:0]      req_event_time,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIN_INDEX_W-1:0] rsp_pin_index,
   output logic                   rsp_rising,
   output logic                   rsp_is_pulse,
   output logic [TIME_W-1:0]      rsp_time_value,
   output logic                   rsp_last_of_run
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      que_push;
   entry_type que_push_entry;
   logic      que_pop;
   entry_type que_head;
   logic      que_full;
   logic      que_empty;

   // Apply register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IRQ_ENABLE:   cfg_in.irq_enable   = csr_wdata[0];
            CSR_ENABLED_PINS: cfg_in.enabled_pins = csr_wdata;
            CSR_PULSE_PINS:   cfg_in.pulse_pins   = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.irq_enable   <= 1'b1;
         cfg_ff.enabled_pins <= '0;
         cfg_ff.pulse_pins   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gep_front #(
      .PIN_COUNT (PIN_COUNT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pin_levels (req_pin_levels),
      .req_event_time (req_event_time),
      .que_full       (que_full),
      .push           (que_push),
      .push_entry     (que_push_entry)
   );

   gep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (que_push),
      .push_entry (que_push_entry),
      .pop        (que_pop),
      .head       (que_head),
      .full       (que_full),
      .empty      (que_empty)
   );

   gep_back #(
      .PIN_COUNT (PIN_COUNT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .que_empty       (que_empty),
      .head            (que_head),
      .pop             (que_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pin_index   (rsp_pin_index),
      .rsp_rising      (rsp_rising),
      .rsp_is_pulse    (rsp_is_pulse),
      .rsp_time_value  (rsp_time_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
